// File: src/sqr_pkg.sv
// sqr_pkg: shared widths, item and corner types and the sine table builder
// for the sprite quad rotation block. No dependencies.
`default_nettype none

package sqr_pkg;

   localparam int SINE_TABLE_DEPTH_DEFAULT = 256;
   localparam int SINE_FRAC_BITS_DEFAULT   = 14;

   localparam int XY_W     = 16;
   localparam int HALF_W   = 15;
   localparam int ANGLE_W  = 16;
   localparam int COLOR_W  = 32;
   localparam int TEX_W    = 16;
   localparam int UV_W     = 17;
   localparam int CORNER_W = 2;
   // corner minus pivot spans +-98302
   localparam int DELTA_W  = 18;

   localparam int XY_MAX = 32767;
   localparam int XY_MIN = -32768;

   // quarter turn in angle units, and pi/2 in Q30
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
   localparam logic [63:0]        PI_HALF_Q30  = 64'd1686629713;

   typedef enum logic [CORNER_W-1:0] {
      CORNER_TL = 2'd0,
      CORNER_TR = 2'd1,
      CORNER_BR = 2'd2,
      CORNER_BL = 2'd3
   } corner_type;

   typedef struct packed {
      logic signed [XY_W-1:0] center_x;
      logic signed [XY_W-1:0] center_y;
      logic [HALF_W-1:0]      half_width;
      logic [HALF_W-1:0]      half_height;
      logic signed [XY_W-1:0] pivot_x;
      logic signed [XY_W-1:0] pivot_y;
      logic [ANGLE_W-1:0]     angle;
      logic [COLOR_W-1:0]     color;
      logic [TEX_W-1:0]       tex_u;
      logic [TEX_W-1:0]       tex_v;
      logic [TEX_W-1:0]       tex_du;
      logic [TEX_W-1:0]       tex_dv;
   } item_type;

   // everything a corner carries besides its rotated products
   typedef struct packed {
      logic signed [XY_W-1:0] pivot_x;
      logic signed [XY_W-1:0] pivot_y;
      logic [COLOR_W-1:0]     color;
      logic [UV_W-1:0]        vert_u;
      logic [UV_W-1:0]        vert_v;
      corner_type             corner;
      logic                   last;
   } vert_side_type;

   // sin(x) for x in Q30, taylor series with truncated terms, rounded half up
   // to frac_bits and clamped to one; evaluated at elaboration only
   function automatic logic [31:0] sine_entry(input logic [63:0] x, input int frac_bits);
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] s;
      logic [63:0] one;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int k = 1; k <= 12; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      s   = (pos > neg) ? pos - neg : 64'd0;
      s   = (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
      one = 64'd1 << frac_bits;
      if (s > one) begin
         s = one;
      end
      return s[31:0];
   endfunction

endpackage

`default_nettype wire

// File: src/sqr_sine_lut.sv
// sqr_sine_lut: quarter-wave sine table built at elaboration, and the
// quadrant folding that gives sine and cosine of one angle. Uses sqr_pkg.
`default_nettype none

module sqr_sine_lut #(
   parameter int SINE_TABLE_DEPTH = sqr_pkg::SINE_TABLE_DEPTH_DEFAULT,
   parameter int SINE_FRAC_BITS   = sqr_pkg::SINE_FRAC_BITS_DEFAULT
) (
   input  wire logic [sqr_pkg::ANGLE_W-1:0]  angle,
   output logic signed [SINE_FRAC_BITS+1:0]  sin_val,
   output logic signed [SINE_FRAC_BITS+1:0]  cos_val
);
   import sqr_pkg::*;

   localparam int SinW = SINE_FRAC_BITS + 2;
   localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam logic [IdxW-1:0] DepthIdx = IdxW'(SINE_TABLE_DEPTH);

   logic [SINE_FRAC_BITS:0] sine_rom [SINE_TABLE_DEPTH+1];
   logic [ANGLE_W-1:0]      cos_angle;

   for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [63:0] Phase = (PI_HALF_Q30 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
      localparam logic [31:0] Entry = sine_entry(Phase, SINE_FRAC_BITS);
      assign sine_rom[gi] = Entry[SINE_FRAC_BITS:0];
   end

   // bit 14 mirrors the quarter wave, bit 15 negates it
   function automatic logic signed [SinW-1:0] fold(input logic [ANGLE_W-1:0] a);
      logic [IdxW+13:0]        scaled;
      logic [IdxW-1:0]         idx;
      logic [SINE_FRAC_BITS:0] mag;
      scaled = (IdxW + 14)'(a[13:0]) * (IdxW + 14)'(SINE_TABLE_DEPTH);
      idx    = scaled[IdxW+13:14];
      mag    = a[14] ? sine_rom[DepthIdx - idx] : sine_rom[idx];
      return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   assign cos_angle = angle + QUARTER_TURN;
   assign sin_val   = fold(angle);
   assign cos_val   = fold(cos_angle);

endmodule

`default_nettype wire

// File: src/sqr_corner.sv
// sqr_corner: holds one rectangle, steps through its four corners and
// registers the four rotation products of each corner. Uses sqr_pkg.
`default_nettype none

module sqr_corner #(
   parameter int SINE_FRAC_BITS = sqr_pkg::SINE_FRAC_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              item_valid,
   input  wire sqr_pkg::item_type                 item,
   input  wire logic signed [SINE_FRAC_BITS+1:0]  sin_val,
   input  wire logic signed [SINE_FRAC_BITS+1:0]  cos_val,
   output logic                                   item_take,
   input  wire logic                              prod_ready,
   output logic                                   prod_valid,
   output logic signed [sqr_pkg::DELTA_W+SINE_FRAC_BITS+1:0] dx_cos,
   output logic signed [sqr_pkg::DELTA_W+SINE_FRAC_BITS+1:0] dy_sin,
   output logic signed [sqr_pkg::DELTA_W+SINE_FRAC_BITS+1:0] dy_cos,
   output logic signed [sqr_pkg::DELTA_W+SINE_FRAC_BITS+1:0] dx_sin,
   output sqr_pkg::vert_side_type                 side
);
   import sqr_pkg::*;

   localparam int SinW  = SINE_FRAC_BITS + 2;
   localparam int ProdW = DELTA_W + SinW;

   // rectangle stage
   logic                    rect_valid_ff, rect_valid_in;
   item_type                rect_ff, rect_in;
   logic signed [SinW-1:0]  sin_ff, sin_in;
   logic signed [SinW-1:0]  cos_ff, cos_in;
   corner_type              corner_ff, corner_in;

   // product stage
   logic                    prod_valid_ff, prod_valid_in;
   logic signed [ProdW-1:0] dx_cos_ff, dx_cos_in;
   logic signed [ProdW-1:0] dy_sin_ff, dy_sin_in;
   logic signed [ProdW-1:0] dy_cos_ff, dy_cos_in;
   logic signed [ProdW-1:0] dx_sin_ff, dx_sin_in;
   vert_side_type           side_ff, side_in;

   logic                      corner_adv;
   logic                      corner_last;
   logic                      right;
   logic                      bottom;
   logic signed [DELTA_W-1:0] pos_x;
   logic signed [DELTA_W-1:0] pos_y;
   logic signed [DELTA_W-1:0] dx;
   logic signed [DELTA_W-1:0] dy;

   assign corner_adv  = rect_valid_ff && (!prod_valid_ff || prod_ready);
   assign corner_last = (corner_ff == CORNER_BL);
   assign item_take   = item_valid && (!rect_valid_ff || (corner_last && corner_adv));

   always_comb begin
      right  = corner_ff inside {CORNER_TR, CORNER_BR};
      bottom = corner_ff inside {CORNER_BR, CORNER_BL};
      pos_x  = right ?
               {{(DELTA_W-XY_W){rect_ff.center_x[XY_W-1]}}, rect_ff.center_x}
                  + {{(DELTA_W-HALF_W){1'b0}}, rect_ff.half_width} :
               {{(DELTA_W-XY_W){rect_ff.center_x[XY_W-1]}}, rect_ff.center_x}
                  - {{(DELTA_W-HALF_W){1'b0}}, rect_ff.half_width};
      pos_y  = bottom ?
               {{(DELTA_W-XY_W){rect_ff.center_y[XY_W-1]}}, rect_ff.center_y}
                  + {{(DELTA_W-HALF_W){1'b0}}, rect_ff.half_height} :
               {{(DELTA_W-XY_W){rect_ff.center_y[XY_W-1]}}, rect_ff.center_y}
                  - {{(DELTA_W-HALF_W){1'b0}}, rect_ff.half_height};
      dx     = pos_x - {{(DELTA_W-XY_W){rect_ff.pivot_x[XY_W-1]}}, rect_ff.pivot_x};
      dy     = pos_y - {{(DELTA_W-XY_W){rect_ff.pivot_y[XY_W-1]}}, rect_ff.pivot_y};
   end

   always_comb begin
      rect_valid_in = rect_valid_ff;
      rect_in       = rect_ff;
      sin_in        = sin_ff;
      cos_in        = cos_ff;
      corner_in     = corner_ff;
      if (item_take) begin
         rect_valid_in = 1'b1;
         rect_in       = item;
         sin_in        = sin_val;
         cos_in        = cos_val;
         corner_in     = CORNER_TL;
      end else if (corner_adv) begin
         if (corner_last) begin
            rect_valid_in = 1'b0;
         end else begin
            corner_in = corner_type'(corner_ff + 2'd1);
         end
      end
   end

   always_comb begin
      prod_valid_in = prod_valid_ff;
      dx_cos_in     = dx_cos_ff;
      dy_sin_in     = dy_sin_ff;
      dy_cos_in     = dy_cos_ff;
      dx_sin_in     = dx_sin_ff;
      side_in       = side_ff;
      if (!prod_valid_ff || prod_ready) begin
         prod_valid_in = rect_valid_ff;
      end
      if (corner_adv) begin
         dx_cos_in      = ProdW'(dx) * ProdW'(cos_ff);
         dy_sin_in      = ProdW'(dy) * ProdW'(sin_ff);
         dy_cos_in      = ProdW'(dy) * ProdW'(cos_ff);
         dx_sin_in      = ProdW'(dx) * ProdW'(sin_ff);
         side_in.pivot_x = rect_ff.pivot_x;
         side_in.pivot_y = rect_ff.pivot_y;
         side_in.color   = rect_ff.color;
         side_in.vert_u  = right ? {1'b0, rect_ff.tex_u} + {1'b0, rect_ff.tex_du} :
                                   {1'b0, rect_ff.tex_u};
         side_in.vert_v  = bottom ? {1'b0, rect_ff.tex_v} + {1'b0, rect_ff.tex_dv} :
                                    {1'b0, rect_ff.tex_v};
         side_in.corner  = corner_ff;
         side_in.last    = corner_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rect_valid_ff <= rect_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
      rect_ff   <= rect_in;
      sin_ff    <= sin_in;
      cos_ff    <= cos_in;
      corner_ff <= corner_in;
      dx_cos_ff <= dx_cos_in;
      dy_sin_ff <= dy_sin_in;
      dy_cos_ff <= dy_cos_in;
      dx_sin_ff <= dx_sin_in;
      side_ff   <= side_in;
   end

   assign prod_valid = prod_valid_ff;
   assign dx_cos     = dx_cos_ff;
   assign dy_sin     = dy_sin_ff;
   assign dy_cos     = dy_cos_ff;
   assign dx_sin     = dx_sin_ff;
   assign side       = side_ff;

endmodule

`default_nettype wire

// File: src/sqr_output.sv
// sqr_output: sums the rotation products, rounds, adds the pivot, saturates
// and holds the result register of the corner channel. Uses sqr_pkg.
`default_nettype none

module sqr_output #(
   parameter int SINE_FRAC_BITS = sqr_pkg::SINE_FRAC_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              prod_valid,
   input  wire logic signed [sqr_pkg::DELTA_W+SINE_FRAC_BITS+1:0] dx_cos,
   input  wire logic signed [sqr_pkg::DELTA_W+SINE_FRAC_BITS+1:0] dy_sin,
   input  wire logic signed [sqr_pkg::DELTA_W+SINE_FRAC_BITS+1:0] dy_cos,
   input  wire logic signed [sqr_pkg::DELTA_W+SINE_FRAC_BITS+1:0] dx_sin,
   input  wire sqr_pkg::vert_side_type            side,
   output logic                                   prod_ready,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [sqr_pkg::XY_W-1:0]        rsp_vert_x,
   output logic signed [sqr_pkg::XY_W-1:0]        rsp_vert_y,
   output logic [sqr_pkg::COLOR_W-1:0]            rsp_vert_color,
   output logic [sqr_pkg::UV_W-1:0]               rsp_vert_u,
   output logic [sqr_pkg::UV_W-1:0]               rsp_vert_v,
   output logic [sqr_pkg::CORNER_W-1:0]           rsp_corner,
   output logic                                   rsp_last
);
   import sqr_pkg::*;

   localparam int ProdW = DELTA_W + SINE_FRAC_BITS + 2;
   localparam int SumW  = ProdW + 1;
   localparam int RndW  = SumW - SINE_FRAC_BITS;
   localparam int PivW  = RndW + 1;

   localparam logic signed [SumW-1:0] HalfLsb =
      {{(SumW-1){1'b0}}, 1'b1} << (SINE_FRAC_BITS - 1);
   localparam logic signed [PivW-1:0] XyMax = PivW'(XY_MAX);
   localparam logic signed [PivW-1:0] XyMin = PivW'(XY_MIN);

   logic                   valid_ff, valid_in;
   logic [XY_W-1:0]        vert_x_ff, vert_x_in;
   logic [XY_W-1:0]        vert_y_ff, vert_y_in;
   vert_side_type          side_ff, side_in;

   logic signed [SumW-1:0] sum_x;
   logic signed [SumW-1:0] sum_y;
   logic signed [PivW-1:0] abs_x;
   logic signed [PivW-1:0] abs_y;

   function automatic logic [XY_W-1:0] sat_xy(input logic signed [PivW-1:0] v);
      logic signed [PivW-1:0] c;
      c = v;
      if (v > XyMax) begin
         c = XyMax;
      end else if (v < XyMin) begin
         c = XyMin;
      end
      return c[XY_W-1:0];
   endfunction

   // round half up: add half an lsb, then floor by the arithmetic part-select
   assign sum_x = SumW'(dx_cos) + SumW'(dy_sin) + HalfLsb;
   assign sum_y = SumW'(dy_cos) - SumW'(dx_sin) + HalfLsb;
   assign abs_x = {sum_x[SumW-1], sum_x[SumW-1:SINE_FRAC_BITS]}
                  + {{(PivW-XY_W){side.pivot_x[XY_W-1]}}, side.pivot_x};
   assign abs_y = {sum_y[SumW-1], sum_y[SumW-1:SINE_FRAC_BITS]}
                  + {{(PivW-XY_W){side.pivot_y[XY_W-1]}}, side.pivot_y};

   assign prod_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in  = valid_ff;
      vert_x_in = vert_x_ff;
      vert_y_in = vert_y_ff;
      side_in   = side_ff;
      if (prod_ready) begin
         valid_in = prod_valid;
         if (prod_valid) begin
            vert_x_in = sat_xy(abs_x);
            vert_y_in = sat_xy(abs_y);
            side_in   = side;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vert_x_ff <= vert_x_in;
      vert_y_ff <= vert_y_in;
      side_ff   <= side_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_vert_x     = vert_x_ff;
   assign rsp_vert_y     = vert_y_ff;
   assign rsp_vert_color = side_ff.color;
   assign rsp_vert_u     = side_ff.vert_u;
   assign rsp_vert_v     = side_ff.vert_v;
   assign rsp_corner     = side_ff.corner;
   assign rsp_last       = side_ff.last;

endmodule

`default_nettype wire

// File: src/sprite_quad_rotation.sv
// sprite_quad_rotation: four rotated corners per rectangle.
// The first corner passes the input register, the rectangle register, the product
// register and the result register; the others follow one per cycle unless stalled.
// The rectangle register holds a rectangle while its four corners are stepped;
// an input register buffers the next rectangle meanwhile.
// Reset (synchronous) empties every stage; the sine table is constant logic.
`default_nettype none

module sprite_quad_rotation #(
   parameter int SINE_TABLE_DEPTH = sqr_pkg::SINE_TABLE_DEPTH_DEFAULT,
   parameter int SINE_FRAC_BITS   = sqr_pkg::SINE_FRAC_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [sqr_pkg::XY_W-1:0]    req_center_x,
   input  wire logic signed [sqr_pkg::XY_W-1:0]    req_center_y,
   input  wire logic [sqr_pkg::HALF_W-1:0]         req_half_width,
   input  wire logic [sqr_pkg::HALF_W-1:0]         req_half_height,
   input  wire logic signed [sqr_pkg::XY_W-1:0]    req_pivot_x,
   input  wire logic signed [sqr_pkg::XY_W-1:0]    req_pivot_y,
   input  wire logic [sqr_pkg::ANGLE_W-1:0]        req_angle,
   input  wire logic [sqr_pkg::COLOR_W-1:0]        req_color,
   input  wire logic [sqr_pkg::TEX_W-1:0]          req_tex_u,
   input  wire logic [sqr_pkg::TEX_W-1:0]          req_tex_v,
   input  wire logic [sqr_pkg::TEX_W-1:0]          req_tex_du,
   input  wire logic [sqr_pkg::TEX_W-1:0]          req_tex_dv,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [sqr_pkg::XY_W-1:0]         rsp_vert_x,
   output logic signed [sqr_pkg::XY_W-1:0]         rsp_vert_y,
   output logic [sqr_pkg::COLOR_W-1:0]             rsp_vert_color,
   output logic [sqr_pkg::UV_W-1:0]                rsp_vert_u,
   output logic [sqr_pkg::UV_W-1:0]                rsp_vert_v,
   output logic [sqr_pkg::CORNER_W-1:0]            rsp_corner,
   output logic                                    rsp_last
);
   import sqr_pkg::*;

   localparam int SinW  = SINE_FRAC_BITS + 2;
   localparam int ProdW = DELTA_W + SinW;

   logic                    in_valid_ff, in_valid_in;
   item_type                item_ff, item_in;
   logic                    in_ready;
   logic                    item_take;

   logic signed [SinW-1:0]  sin_val;
   logic signed [SinW-1:0]  cos_val;

   logic                    prod_valid;
   logic                    prod_ready;
   logic signed [ProdW-1:0] dx_cos;
   logic signed [ProdW-1:0] dy_sin;
   logic signed [ProdW-1:0] dy_cos;
   logic signed [ProdW-1:0] dx_sin;
   vert_side_type           side;

   assign in_ready  = !in_valid_ff || item_take;
   assign req_stall = !in_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (in_ready) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            item_in.center_x    = req_center_x;
            item_in.center_y    = req_center_y;
            item_in.half_width  = req_half_width;
            item_in.half_height = req_half_height;
            item_in.pivot_x     = req_pivot_x;
            item_in.pivot_y     = req_pivot_y;
            item_in.angle       = req_angle;
            item_in.color       = req_color;
            item_in.tex_u       = req_tex_u;
            item_in.tex_v       = req_tex_v;
            item_in.tex_du      = req_tex_du;
            item_in.tex_dv      = req_tex_dv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      item_ff <= item_in;
   end

   sqr_sine_lut #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SINE_FRAC_BITS   (SINE_FRAC_BITS)
   ) u_sine_lut (
      .angle   (item_ff.angle),
      .sin_val (sin_val),
      .cos_val (cos_val)
   );

   sqr_corner #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_corner (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (item_ff),
      .sin_val    (sin_val),
      .cos_val    (cos_val),
      .item_take  (item_take),
      .prod_ready (prod_ready),
      .prod_valid (prod_valid),
      .dx_cos     (dx_cos),
      .dy_sin     (dy_sin),
      .dy_cos     (dy_cos),
      .dx_sin     (dx_sin),
      .side       (side)
   );

   sqr_output #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_output (
      .clock          (clock),
      .reset          (reset),
      .prod_valid     (prod_valid),
      .dx_cos         (dx_cos),
      .dy_sin         (dy_sin),
      .dy_cos         (dy_cos),
      .dx_sin         (dx_sin),
      .side           (side),
      .prod_ready     (prod_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_vert_x     (rsp_vert_x),
      .rsp_vert_y     (rsp_vert_y),
      .rsp_vert_color (rsp_vert_color),
      .rsp_vert_u     (rsp_vert_u),
      .rsp_vert_v     (rsp_vert_v),
      .rsp_corner     (rsp_corner),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// File: src/sqr_checker.sv
// sqr_checker: port-level checks on the corner sequence of
// sprite_quad_rotation, bound to the top level below. Uses sqr_pkg.
`default_nettype none

module sqr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic signed [sqr_pkg::XY_W-1:0] rsp_vert_x,
   input wire logic [sqr_pkg::COLOR_W-1:0]     rsp_vert_color,
   input wire logic [sqr_pkg::CORNER_W-1:0]    rsp_corner,
   input wire logic                            rsp_last
);
   import sqr_pkg::*;

   // last marks the bottom-left corner and nothing else
   a_last_on_bl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_corner == CORNER_BL)))
      else $error("last flag does not match corner");

   // corners of one rectangle come out in order
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last)
         |=> (!rsp_valid || rsp_corner == $past(rsp_corner) + 2'd1))
      else $error("corner out of order");

   // a new rectangle opens with the top-left corner
   a_new_rect_tl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last)
         |=> (!rsp_valid || rsp_corner == CORNER_TL))
      else $error("rectangle does not start at top-left");

   // all corners of one rectangle share the color
   a_color_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last)
         |=> (!rsp_valid || rsp_vert_color == $past(rsp_vert_color)))
      else $error("color changed inside a rectangle");

   // a stalled corner holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_vert_x)))
      else $error("stalled transfer changed");

endmodule

bind sprite_quad_rotation sqr_checker u_sqr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_vert_x     (rsp_vert_x),
   .rsp_vert_color (rsp_vert_color),
   .rsp_corner     (rsp_corner),
   .rsp_last       (rsp_last)
);

`default_nettype wire
